// File: rtl/bitmap_text_rect_generator_top_assert.svh
// Assertion macros for the bitmap text square generator.
// Used by the top level; expects clk and rst_n in the scope of each use.
`ifndef BITMAP_TEXT_RECT_GENERATOR_TOP_ASSERT_SVH
`define BITMAP_TEXT_RECT_GENERATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTRG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/btrg_pkg.sv
// Shared types, constants and font tables of the bitmap text square generator.
// No dependencies; every RTL module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package btrg_pkg;

  localparam int FONT_W         = 5;
  localparam int FONT_H         = 7;
  localparam int GLYPH_BITS     = FONT_W * FONT_H;
  localparam int LINE_COUNT_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 24;

  // Font table indexes.
  localparam logic [5:0] F_SPACE = 6'd0;
  localparam logic [5:0] F_BOX   = 6'd1;
  localparam logic [5:0] F_ALPHA = 6'd2;
  localparam logic [5:0] F_DIGIT = 6'd28;
  localparam logic [5:0] F_PUNCT = 6'd38;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE    = 4'd0,
    CFG_CHAR_GAP = 4'd1,
    CFG_LINE_GAP = 4'd2,
    CFG_FG_COLOR = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]         ch;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [2:0]         line_index;
    logic               first_of_line;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [3:0]         rect_size;
    logic [23:0]        color;
    logic               last;
  } out_item_t;

  // One character's drawing job, handed from the front to the back.
  typedef struct packed {
    logic [GLYPH_BITS-1:0] glyph;
    logic signed [15:0]    x0;
    logic signed [16:0]    ybase;
    logic [3:0]            size;
    logic [23:0]           color;
  } job_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // Clamp a 17-bit signed value into the 16-bit signed range.
  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = {v[16], {15{~v[16]}}};
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Map a character code to its font table index.
  function automatic logic [5:0] font_index(input logic [7:0] ch);
    logic [7:0] c;
    logic [5:0] idx;
    c = ch;
    if (c >= 8'h61 && c <= 8'h7a) begin
      c = c - 8'd32;
    end
    if (c == 8'h20) begin
      idx = F_SPACE;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      idx = F_ALPHA + 6'(c - 8'h41);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      idx = F_DIGIT + 6'(c - 8'h30);
    end else begin
      case (c)
        8'h3a:   idx = F_PUNCT;
        8'h2e:   idx = F_PUNCT + 6'd1;
        8'h2f:   idx = F_PUNCT + 6'd2;
        8'h2d:   idx = F_PUNCT + 6'd3;
        8'h5f:   idx = F_PUNCT + 6'd4;
        8'h25:   idx = F_PUNCT + 6'd5;
        8'h2b:   idx = F_PUNCT + 6'd6;
        8'h7c:   idx = F_PUNCT + 6'd7;
        default: idx = F_BOX;
      endcase
    end
    return idx;
  endfunction

  // Font bitmap: top row in the high bits, left column as bit 4 of each row.
  function automatic logic [GLYPH_BITS-1:0] font_rom(input logic [5:0] idx);
    logic [GLYPH_BITS-1:0] g;
    case (idx)
      6'd0:    g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
      6'd1:    g = {5'd31, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd31};
      6'd2:    g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd3:    g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      6'd4:    g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      6'd5:    g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      6'd6:    g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      6'd7:    g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd8:    g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      6'd9:    g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd10:   g = {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      6'd11:   g = {5'd7, 5'd2, 5'd2, 5'd2, 5'd18, 5'd18, 5'd12};
      6'd12:   g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      6'd13:   g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      6'd14:   g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      6'd15:   g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      6'd16:   g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd17:   g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd18:   g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      6'd19:   g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      6'd20:   g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      6'd21:   g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      6'd22:   g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd23:   g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      6'd24:   g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      6'd25:   g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      6'd26:   g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      6'd27:   g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      6'd28:   g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      6'd29:   g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      6'd30:   g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      6'd31:   g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      6'd32:   g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      6'd33:   g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      6'd34:   g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      6'd35:   g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      6'd36:   g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      6'd37:   g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      6'd38:   g = {5'd0, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4, 5'd0};
      6'd39:   g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
      6'd40:   g = {5'd1, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd16};
      6'd41:   g = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      6'd42:   g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
      6'd43:   g = {5'd24, 5'd25, 5'd2, 5'd4, 5'd8, 5'd19, 5'd3};
      6'd44:   g = {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
      6'd45:   g = {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      default: g = {5'd31, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd31};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/btrg_front.sv
// Front part: configuration registers, cursor, font lookup and job building.
// Depends on btrg_pkg; feeds btrg_queue.
`timescale 1ns / 1ps
`default_nettype none

module btrg_front #(
  parameter int LINE_COUNT = btrg_pkg::LINE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  btrg_pkg::in_item_t                   in_data,
  input  logic                                 cfg_valid,
  input  logic [btrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btrg_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 q_push,
  output btrg_pkg::job_t                       q_push_data
);
  import btrg_pkg::*;

  localparam logic [6:0] LineLimit = 7'(LINE_COUNT);

  logic [3:0]         scale_r,    scale_nxt;
  logic [7:0]         char_gap_r, char_gap_nxt;
  logic [7:0]         line_gap_r, line_gap_nxt;
  logic [23:0]        fg_color_r, fg_color_nxt;
  logic signed [15:0] cursor_r,   cursor_nxt;

  logic               accept;
  logic               line_ok;
  logic [3:0]         s_eff;
  logic [8:0]         pitch;
  logic [11:0]        line_off;
  logic signed [15:0] cur_use;
  logic signed [16:0] cur_adv;
  logic [5:0]         fidx;

  // Configuration writes; unknown indexes are dropped.
  always_comb begin
    scale_nxt    = scale_r;
    char_gap_nxt = char_gap_r;
    line_gap_nxt = line_gap_r;
    fg_color_nxt = fg_color_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE:    scale_nxt    = cfg_data[3:0];
        CFG_CHAR_GAP: char_gap_nxt = cfg_data[7:0];
        CFG_LINE_GAP: line_gap_nxt = cfg_data[7:0];
        CFG_FG_COLOR: fg_color_nxt = cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Per-character arithmetic and font lookup.
  always_comb begin
    accept   = in_valid && !in_stall;
    line_ok  = {4'd0, in_data.line_index} < LineLimit;
    s_eff    = (scale_r == 4'd0) ? 4'd1 : scale_r;
    pitch    = 9'(s_eff) * 9'(FONT_H) + 9'(line_gap_r);
    line_off = 12'(in_data.line_index) * 12'(pitch);
    cur_use  = in_data.first_of_line ? in_data.origin_x : cursor_r;
    cur_adv  = 17'(cur_use) + $signed({8'd0, 9'(s_eff) * 9'(FONT_W)})
             + $signed({9'd0, char_gap_r});
    fidx     = font_index(in_data.ch);

    cursor_nxt = cursor_r;
    if (accept && line_ok) begin
      cursor_nxt = sat16(cur_adv);
    end

    q_push            = accept && line_ok && (fidx != F_SPACE);
    q_push_data.glyph = font_rom(fidx);
    q_push_data.x0    = cur_use;
    q_push_data.ybase = 17'(in_data.origin_y) + $signed({5'd0, line_off});
    q_push_data.size  = s_eff;
    q_push_data.color = fg_color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= 4'd1;
      char_gap_r <= 8'd1;
      line_gap_r <= 8'd2;
      fg_color_r <= 24'd0;
      cursor_r   <= 16'sd0;
    end else begin
      scale_r    <= scale_nxt;
      char_gap_r <= char_gap_nxt;
      line_gap_r <= line_gap_nxt;
      fg_color_r <= fg_color_nxt;
      cursor_r   <= cursor_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/btrg_queue.sv
// Short job queue between the front and the back parts.
// Depends on btrg_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module btrg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  btrg_pkg::job_t       push_data,
  input  logic                 pop,
  output logic                 pop_valid,
  output btrg_pkg::job_t       pop_data,
  output btrg_pkg::q_status_t  status
);
  import btrg_pkg::*;

  localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r,    cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign pop_valid    = (cnt_r != '0);
  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign status.count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/btrg_back.sv
// Back part: scans one glyph a pixel per cycle while the output is not stalled, and emits square commands.
// Depends on btrg_pkg; takes jobs from btrg_queue.
`timescale 1ns / 1ps
`default_nettype none

module btrg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  btrg_pkg::job_t      q_data,
  output logic                q_pop,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output btrg_pkg::out_item_t out_data
);
  import btrg_pkg::*;

  localparam logic [2:0] LastCol = 3'(FONT_W - 1);

  logic                  busy_r,      busy_nxt;
  logic [GLYPH_BITS-1:0] sh_r,        sh_nxt;
  logic [2:0]            col_r,       col_nxt;
  logic signed [16:0]    x_r,         x_nxt;
  logic signed [16:0]    y_r,         y_nxt;
  logic signed [15:0]    x0_r,        x0_nxt;
  logic [3:0]            s_r,         s_nxt;
  logic [23:0]           color_r,     color_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r,  out_data_nxt;

  logic can_step;
  logic step;
  logic rest_zero;
  logic finish;
  logic load;

  // Scan control: one glyph position per cycle while the output can take it.
  always_comb begin
    can_step  = !out_valid_r || !out_stall;
    step      = busy_r && can_step;
    rest_zero = (sh_r[GLYPH_BITS-2:0] == '0);
    finish    = step && rest_zero;
    load      = q_valid && (!busy_r || finish);
  end

  // Scan registers.
  always_comb begin
    busy_nxt  = busy_r;
    sh_nxt    = sh_r;
    col_nxt   = col_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    x0_nxt    = x0_r;
    s_nxt     = s_r;
    color_nxt = color_r;
    if (finish) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt  = 1'b1;
      sh_nxt    = q_data.glyph;
      col_nxt   = 3'd0;
      x_nxt     = 17'(q_data.x0);
      y_nxt     = q_data.ybase;
      x0_nxt    = q_data.x0;
      s_nxt     = q_data.size;
      color_nxt = q_data.color;
    end else if (step) begin
      sh_nxt = {sh_r[GLYPH_BITS-2:0], 1'b0};
      if (col_r == LastCol) begin
        col_nxt = 3'd0;
        x_nxt   = 17'(x0_r);
        y_nxt   = y_r + $signed({13'd0, s_r});
      end else begin
        col_nxt = col_r + 3'd1;
        x_nxt   = x_r + $signed({13'd0, s_r});
      end
    end
  end

  // Output register: loaded on a lit pixel, held while stalled.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (step && sh_r[GLYPH_BITS-1]) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.rect_x    = sat16(x_r);
      out_data_nxt.rect_y    = sat16(y_r);
      out_data_nxt.rect_size = s_r;
      out_data_nxt.color     = color_r;
      out_data_nxt.last      = rest_zero;
    end
  end

  assign q_pop     = load;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    col_r      <= col_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    x0_r       <= x0_nxt;
    s_r        <= s_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/bitmap_text_rect_generator_top.sv
// Top level of the bitmap text square generator: front, job queue and back.
// Depends on btrg_pkg, btrg_front, btrg_queue, btrg_back and the assert header.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_item_t (one character)
//   out_     output     out_valid/out_stall out_item_t (one square)
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// The front takes one character per cycle while not stalled, into a two-entry
// job queue. The back scans each glyph one pixel position per cycle while its
// output is not stalled, and stops after the last lit pixel; a space or an
// out-of-range line is dropped by the front and never reaches the queue.
// Reset is synchronous and active low; an output stall freezes the scan while a
// square is waiting; an input stall is raised only while the job queue is full.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_text_rect_generator_top_assert.svh"

module bitmap_text_rect_generator_top #(
  parameter int LINE_COUNT = btrg_pkg::LINE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  btrg_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output btrg_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [btrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btrg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import btrg_pkg::*;

  logic      q_push;
  job_t      q_push_data;
  logic      q_pop;
  logic      q_valid;
  job_t      q_data;
  q_status_t q_stat;
  logic      back_busy;

  // Registers are always writable.
  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;

  btrg_front #(
    .LINE_COUNT(LINE_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_push     (q_push),
    .q_push_data(q_push_data)
  );

  btrg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_data),
    .status   (q_stat)
  );

  btrg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .busy     (back_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // A square that is not the last one means the glyph scan is still running.
  `BTRG_ASSERT_SAME(a_more_pending, out_valid && !out_data.last, back_busy, "scan ended early")
  // The front never writes a full queue.
  `BTRG_ASSERT_SAME(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  // A pushed job is held in the queue on the following cycle.
  `BTRG_ASSERT_NEXT(a_push_lands, q_push, q_stat.count != '0, "pushed job lost")

endmodule

`default_nettype wire

// File: verif/bitmap_text_rect_generator_top_tb.sv
// Self-checking testbench for the bitmap text square generator top level.
// Needs btrg_pkg and the RTL of bitmap_text_rect_generator_top; nothing else.
`timescale 1ns / 1ps

module bitmap_text_rect_generator_top_tb;
  import btrg_pkg::*;

  localparam int LINE_COUNT   = LINE_COUNT_DEF;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 40;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies seen by the predictor, at their reset values.
  logic [3:0]  cfg_scale    = 4'd1;
  logic [7:0]  cfg_char_gap = 8'd1;
  logic [7:0]  cfg_line_gap = 8'd2;
  logic [23:0] cfg_color    = 24'd0;
  int          pen_x        = 0;

  in_item_t  chars_pending[$];
  out_item_t squares_due[$];
  int        items_queued   = 0;
  int        items_accepted = 0;
  int        cfg_writes     = 0;
  int        errors         = 0;
  int        cycle_count    = 0;
  logic      in_fire        = 1'b0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_asked     = 0;
  int hold_granted   = 0;
  int hold_left      = 0;

  string mark_chars = ":./-_%+|";

  bitmap_text_rect_generator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pack seven 5-bit rows, top row in the high bits.
  function automatic logic [GLYPH_BITS-1:0] rows7(input int r0, r1, r2, r3, r4, r5, r6);
    return {r0[4:0], r1[4:0], r2[4:0], r3[4:0], r4[4:0], r5[4:0], r6[4:0]};
  endfunction

  // Character code to its 5x7 bitmap; lower case shares the upper-case shapes.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0]            c;
    logic [GLYPH_BITS-1:0] g;
    c = code;
    if (c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end
    case (c)
      " ": g = '0;
      "A": g = rows7(14, 17, 17, 31, 17, 17, 17);
      "B": g = rows7(30, 17, 17, 30, 17, 17, 30);
      "C": g = rows7(14, 17, 16, 16, 16, 17, 14);
      "D": g = rows7(30, 17, 17, 17, 17, 17, 30);
      "E": g = rows7(31, 16, 16, 30, 16, 16, 31);
      "F": g = rows7(31, 16, 16, 30, 16, 16, 16);
      "G": g = rows7(14, 17, 16, 23, 17, 17, 15);
      "H": g = rows7(17, 17, 17, 31, 17, 17, 17);
      "I": g = rows7(14, 4, 4, 4, 4, 4, 14);
      "J": g = rows7(7, 2, 2, 2, 18, 18, 12);
      "K": g = rows7(17, 18, 20, 24, 20, 18, 17);
      "L": g = rows7(16, 16, 16, 16, 16, 16, 31);
      "M": g = rows7(17, 27, 21, 21, 17, 17, 17);
      "N": g = rows7(17, 25, 21, 19, 17, 17, 17);
      "O": g = rows7(14, 17, 17, 17, 17, 17, 14);
      "P": g = rows7(30, 17, 17, 30, 16, 16, 16);
      "Q": g = rows7(14, 17, 17, 17, 21, 18, 13);
      "R": g = rows7(30, 17, 17, 30, 20, 18, 17);
      "S": g = rows7(15, 16, 16, 14, 1, 1, 30);
      "T": g = rows7(31, 4, 4, 4, 4, 4, 4);
      "U": g = rows7(17, 17, 17, 17, 17, 17, 14);
      "V": g = rows7(17, 17, 17, 17, 17, 10, 4);
      "W": g = rows7(17, 17, 17, 21, 21, 21, 10);
      "X": g = rows7(17, 17, 10, 4, 10, 17, 17);
      "Y": g = rows7(17, 17, 10, 4, 4, 4, 4);
      "Z": g = rows7(31, 1, 2, 4, 8, 16, 31);
      "0": g = rows7(14, 17, 19, 21, 25, 17, 14);
      "1": g = rows7(4, 12, 4, 4, 4, 4, 14);
      "2": g = rows7(14, 17, 1, 2, 4, 8, 31);
      "3": g = rows7(30, 1, 1, 14, 1, 1, 30);
      "4": g = rows7(2, 6, 10, 18, 31, 2, 2);
      "5": g = rows7(31, 16, 16, 30, 1, 1, 30);
      "6": g = rows7(14, 16, 16, 30, 17, 17, 14);
      "7": g = rows7(31, 1, 2, 4, 8, 8, 8);
      "8": g = rows7(14, 17, 17, 14, 17, 17, 14);
      "9": g = rows7(14, 17, 17, 15, 1, 1, 14);
      ":": g = rows7(0, 4, 4, 0, 4, 4, 0);
      ".": g = rows7(0, 0, 0, 0, 0, 12, 12);
      "/": g = rows7(1, 1, 2, 4, 8, 16, 16);
      "-": g = rows7(0, 0, 0, 31, 0, 0, 0);
      "_": g = rows7(0, 0, 0, 0, 0, 0, 31);
      "%": g = rows7(24, 25, 2, 4, 8, 19, 3);
      "+": g = rows7(0, 4, 4, 31, 4, 4, 0);
      "|": g = rows7(4, 4, 4, 4, 4, 4, 4);
      default: g = rows7(31, 17, 17, 17, 17, 17, 31);
    endcase
    return g;
  endfunction

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Expand one character into its squares and advance the cursor; an out-of-range line is skipped.
  task automatic draw_char(input in_item_t it);
    logic [GLYPH_BITS-1:0] g;
    int        s;
    int        ybase;
    int        row;
    int        col;
    out_item_t sq;
    out_item_t prev;
    logic      have_prev;
    s = (cfg_scale == 4'd0) ? 1 : int'(cfg_scale);
    have_prev = 1'b0;
    prev = '0;
    if (int'(it.line_index) >= LINE_COUNT) return;
    if (it.first_of_line) pen_x = $signed(it.origin_x);
    ybase = $signed(it.origin_y) + int'(it.line_index) * (FONT_H * s + int'(cfg_line_gap));
    g = glyph_bits(it.ch);
    for (row = 0; row < FONT_H; row++) begin
      for (col = 0; col < FONT_W; col++) begin
        if (g[GLYPH_BITS - 1 - (row * FONT_W + col)]) begin
          sq.rect_x    = 16'(clip16(pen_x + col * s));
          sq.rect_y    = 16'(clip16(ybase + row * s));
          sq.rect_size = 4'(s);
          sq.color     = cfg_color;
          sq.last      = 1'b0;
          if (have_prev) squares_due.push_back(prev);
          prev = sq;
          have_prev = 1'b1;
        end
      end
    end
    // The final square of the character carries the last flag.
    if (have_prev) begin
      prev.last = 1'b1;
      squares_due.push_back(prev);
    end
    pen_x = clip16(pen_x + FONT_W * s + int'(cfg_char_gap));
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endtask

  // Sample every transfer at the rising edge: predict, compare, track registers.
  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        draw_char(in_data);
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (squares_due.size() == 0) begin
          $error("square transfer with nothing expected: x %0d y %0d",
                 $signed(out_data.rect_x), $signed(out_data.rect_y));
          errors++;
        end else begin
          want = squares_due.pop_front();
          check_field("rect_x", $signed(want.rect_x), $signed(out_data.rect_x));
          check_field("rect_y", $signed(want.rect_y), $signed(out_data.rect_y));
          check_field("rect_size", int'(want.rect_size), int'(out_data.rect_size));
          check_field("color", int'(want.color), int'(out_data.color));
          check_field("last", int'(want.last), int'(out_data.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE:    cfg_scale    = cfg_data[3:0];
          CFG_CHAR_GAP: cfg_char_gap = cfg_data[7:0];
          CFG_LINE_GAP: cfg_line_gap = cfg_data[7:0];
          CFG_FG_COLOR: cfg_color    = cfg_data[23:0];
          default:      ;
        endcase
        cfg_writes++;
      end
    end else begin
      in_fire = 1'b0;
    end
  end

  // Character driver: hold a stalled transfer, else maybe present the next item.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (chars_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_data  <= chars_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Square receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_asked != hold_granted) begin
      hold_granted = hold_asked;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] ch, input int ox, input int oy,
                           input int line, input logic first);
    in_item_t it;
    it.ch            = ch;
    it.origin_x      = 16'(ox);
    it.origin_y      = 16'(oy);
    it.line_index    = 3'(line);
    it.first_of_line = first;
    chars_pending.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || squares_due.size() != 0) @(negedge clk);
  endtask

  // Wait for the block to go idle, including a trailing space still in flight.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_writes < target);
    cfg_valid <= 1'b0;
  endtask

  // Write all four registers; unused upper data bits get random junk half the time.
  task automatic set_regs(input int scale, input int cgap, input int lgap, input int color);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(1) == 1) ? CFG_DATA_W'($urandom) : '0;
    write_reg(CFG_SCALE, {junk[23:4], 4'(scale)});
    write_reg(CFG_CHAR_GAP, {junk[23:8], 8'(cgap)});
    write_reg(CFG_LINE_GAP, {junk[23:8], 8'(lgap)});
    write_reg(CFG_FG_COLOR, 24'(color));
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return "A" + 8'($urandom_range(25));
    if (r < 55) return "a" + 8'($urandom_range(25));
    if (r < 68) return "0" + 8'($urandom_range(9));
    if (r < 80) return mark_chars[$urandom_range(7)];
    if (r < 87) return " ";
    return 8'($urandom_range(255));
  endfunction

  // One line of text at a shared origin, cursor loaded by the first character.
  task automatic queue_text(input int n);
    int ox;
    int oy;
    int line;
    int k;
    if ($urandom_range(3) == 0) begin
      ox = $signed(16'($urandom));
      oy = $signed(16'($urandom));
    end else begin
      ox = $urandom_range(700) - 100;
      oy = $urandom_range(500) - 100;
    end
    line = $urandom_range(7);
    for (k = 0; k < n; k++) begin
      send_char(pick_char(), ox, oy, line, k == 0);
    end
  endtask

  // Mostly text lines, some items with every field random.
  task automatic queue_random(input int count);
    int done;
    int n;
    done = 0;
    while (done < count) begin
      if ($urandom_range(9) == 0) begin
        send_char(8'($urandom), $signed(16'($urandom)), $signed(16'($urandom)),
                  $urandom_range(7), 1'($urandom));
        done++;
      end else begin
        n = $urandom_range(1, 8);
        // Keep the batch at the requested size.
        if (n > count - done) n = count - done;
        queue_text(n);
        done += n;
      end
    end
  endtask

  initial begin
    int setting;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: every glyph class, case folding, boxes, extremes.
    send_char("A", 0, 0, 0, 1'b1);
    send_char("z", 0, 0, 0, 1'b0);
    send_char("0", 0, 0, 0, 1'b0);
    send_char("9", 0, 0, 0, 1'b0);
    send_char(":", 0, 0, 0, 1'b0);
    send_char("|", 0, 0, 0, 1'b0);
    send_char(" ", 0, 0, 0, 1'b0);
    send_char(8'd0, 0, 0, 0, 1'b0);
    send_char(8'd255, 0, 0, 0, 1'b0);
    send_char(8'd128, 0, 0, 0, 1'b0);
    send_char("W", 32767, 32767, 7, 1'b1);
    send_char("M", -32768, -32768, 0, 1'b1);
    send_char("8", 100, -50, 7, 1'b0);
    wait_idle();

    // Register extremes: saturation of the cursor and both coordinates.
    set_regs(15, 255, 255, 24'hFFFFFF);
    send_char("B", 32600, 32000, 7, 1'b1);
    send_char("%", 32600, 32000, 7, 1'b0);
    send_char(" ", 32600, 32000, 7, 1'b0);
    send_char("_", -32768, -32768, 0, 1'b1);
    wait_idle();

    // Writes to undecoded indexes must leave the registers alone.
    write_reg(CFG_UNUSED_LO, 24'h000003);
    write_reg(CFG_UNUSED_HI, 24'hABCDEF);
    send_char("+", 10, 10, 1, 1'b1);
    wait_idle();

    // A scale of zero draws as scale one.
    set_regs(0, 0, 0, 0);
    send_char("X", 0, 0, 3, 1'b1);
    send_char("h", 0, 0, 3, 1'b0);
    send_char("/", 0, 0, 3, 1'b0);
    wait_idle();

    // Random part: several register settings and idling phases.
    for (setting = 0; setting < 8; setting++) begin
      case (setting)
        1: set_regs(15, 255, 255, 24'hFFFFFF);
        2: set_regs(0, 0, 0, 0);
        3: set_regs(1, $urandom_range(255), $urandom_range(255), $urandom);
        default: set_regs($urandom_range(15), $urandom_range(255), $urandom_range(255),
                          $urandom);
      endcase
      if (setting == 5) write_reg(CFG_UNUSED_LO + 4'($urandom_range(11)), $urandom);
      case (setting % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      // Long receiver hold-off while the sender keeps offering characters.
      if (setting == 0) hold_asked++;
      queue_random(25);
      // Sender pauses here until every expected square has arrived.
      wait_drained();
      queue_random(25);
      wait_idle();
    end

    src_idle_pct = 0;
    sink_stall_pct = 0;
    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0 && squares_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
